### rtl/ttf_pkg.sv
package ttf_pkg;

   // multiplier operand width: a 33-bit signed delta, or a 30-bit magnitude
   localparam int DW = 33;
   // accumulator width: holds the difference of two 66-bit products
   localparam int AW = 67;
   // normalized magnitude width before the sum of squares
   localparam int NORM_BITS = 30;
   // Q1.14 output scale
   localparam int Q_SHIFT = 14;
   localparam int QW = 16;
   // root/divide unit widths
   localparam int RW = 34;
   localparam int ROOT_IN_W = 62;
   localparam int ROOT_W = 31;
   localparam int NUM_W = 45;
   localparam int SQRT_STEPS = 31;
   localparam int DIV_STEPS = 16;

   typedef enum logic [1:0] {
      MAC_LOAD = 2'd0,
      MAC_ADD  = 2'd1,
      MAC_SUB  = 2'd2
   } mac_op_type;

   typedef struct packed {
      logic       valid;
      mac_op_type op;
   } mac_cmd_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } rdu_cmd_type;

endpackage

### rtl/ttf_mac.sv
module ttf_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  ttf_pkg::mac_cmd_type              cmd,
   input  logic signed [ttf_pkg::DW-1:0]     op_a,
   input  logic signed [ttf_pkg::DW-1:0]     op_b,
   output logic signed [ttf_pkg::AW-1:0]     acc
);
   import ttf_pkg::*;

   logic signed [2*DW-1:0] prod_ff, prod_in;
   logic                   pv_ff, pv_in;
   mac_op_type             pop_ff, pop_in;
   logic signed [AW-1:0]   acc_ff, acc_in;
   logic signed [AW-1:0]   prod_ext;

   // product stage
   always_comb begin
      prod_in = op_a * op_b;
      pv_in   = cmd.valid;
      pop_in  = cmd.op;
   end

   // accumulate stage
   always_comb begin
      prod_ext = AW'(prod_ff);
      acc_in   = acc_ff;
      if (pv_ff) begin
         case (pop_ff)
            MAC_LOAD: acc_in = prod_ext;
            MAC_ADD:  acc_in = acc_ff + prod_ext;
            MAC_SUB:  acc_in = acc_ff - prod_ext;
            default:  acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      pop_ff  <= pop_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

### rtl/ttf_rdu.sv
module ttf_rdu (
   input  logic                              clock,
   input  logic                              reset,
   input  ttf_pkg::rdu_cmd_type              cmd,
   input  logic [ttf_pkg::ROOT_IN_W-1:0]     num,
   input  logic [ttf_pkg::ROOT_W-1:0]        den,
   output logic                              done,
   output logic [ttf_pkg::ROOT_W-1:0]        result
);
   import ttf_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 div_ff, div_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [ROOT_IN_W-1:0] x_ff, x_in;
   logic [RW-1:0]        rem_ff, rem_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic [ROOT_W-1:0]    den_ff, den_in;
   logic [RW-1:0]        rem_sh, trial;
   logic [RW:0]          diff;
   logic                 ge;

   // one restoring step: sqrt takes two bits per step, divide one
   always_comb begin
      rem_sh = div_ff ? {rem_ff[RW-2:0], x_ff[ROOT_IN_W-1]}
                      : {rem_ff[RW-3:0], x_ff[ROOT_IN_W-1 -: 2]};
      trial  = div_ff ? RW'(den_ff) : RW'({root_ff, 2'b01});
      diff   = {1'b0, rem_sh} - {1'b0, trial};
      ge     = ~diff[RW];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      den_in  = den_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         div_in  = cmd.is_div;
         den_in  = den;
         root_in = '0;
         if (cmd.is_div) begin
            x_in   = {num[DIV_STEPS-1:0], (ROOT_IN_W-DIV_STEPS)'(0)};
            rem_in = RW'(num[NUM_W-1:DIV_STEPS]);
            cnt_in = 5'(DIV_STEPS - 1);
         end else begin
            x_in   = num;
            rem_in = '0;
            cnt_in = 5'(SQRT_STEPS - 1);
         end
      end else if (busy_ff) begin
         rem_in  = ge ? diff[RW-1:0] : rem_sh;
         root_in = {root_ff[ROOT_W-2:0], ge};
         x_in    = div_ff ? (x_ff << 1) : (x_ff << 2);
         cnt_in  = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      den_ff  <= den_in;
   end

   assign done   = done_ff;
   assign result = root_ff;

endmodule

### rtl/triangle_tangent_frame.sv
// Per-triangle tangent and bitangent from texture coordinates.
// Input channel (req_*): one vertex per transaction, position and UV in
// signed Q16.16. Corners 0 and 1 are held; corner 2 starts the work.
// Result channel (rsp_*): three transactions per triangle, one per corner,
// each with the unit tangent and bitangent in Q1.14, the corner slot, a
// degenerate flag (set on a zero UV determinant, with zero vectors) and a last flag.
// Operation: corners 0 and 1 are only stored; corner 2 runs a sequencer
// over one shared multiply-accumulate unit (14 products for the
// determinant and both vectors) and one shared shift-subtract unit
// (31-step square root, then three 16-step divides per vector). A
// one-bit-per-cycle shifter normalizes each vector before its sum of
// squares. A degenerate triangle goes to the output straight after the
// products, and a zero vector skips the root and the divides. Results
// leave one per cycle without stalls, and the block takes no vertex
// until the third result has been taken.
// Reset: synchronous, clears the sequencer and the corner count.
// Stall: the result registers hold while rsp_ready is low; the block
// waits in its output state and accepts nothing meanwhile.
module triangle_tangent_frame (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [31:0] req_tex_u,
   input  logic [31:0] req_tex_v,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_tangent_x,
   output logic [15:0] rsp_tangent_y,
   output logic [15:0] rsp_tangent_z,
   output logic [15:0] rsp_bitan_x,
   output logic [15:0] rsp_bitan_y,
   output logic [15:0] rsp_bitan_z,
   output logic [1:0]  rsp_vertex_slot,
   output logic        rsp_degenerate,
   output logic        rsp_last_of_triangle
);
   import ttf_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b00000001,
      ST_MUL  = 8'b00000010,
      ST_LOAD = 8'b00000100,
      ST_NORM = 8'b00001000,
      ST_SQ   = 8'b00010000,
      ST_ROOT = 8'b00100000,
      ST_DIV  = 8'b01000000,
      ST_OUT  = 8'b10000000
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           corner_ff, corner_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic                 vec_ff, vec_in;
   logic [1:0]           comp_ff, comp_in;
   logic                 run_ff, run_in;
   logic [1:0]           slot_ff, slot_in;
   logic                 degen_ff, degen_in;

   logic [31:0]          held_pos_ff [6];
   logic [31:0]          held_pos_in [6];
   logic [31:0]          held_tex_ff [4];
   logic [31:0]          held_tex_in [4];
   logic signed [DW-1:0] e0_ff [3];
   logic signed [DW-1:0] e0_in [3];
   logic signed [DW-1:0] e1_ff [3];
   logic signed [DW-1:0] e1_in [3];
   logic signed [DW-1:0] du0_ff, du0_in, dv0_ff, dv0_in;
   logic signed [DW-1:0] du1_ff, du1_in, dv1_ff, dv1_in;
   logic signed [AW-1:0] res_ff [7];
   logic signed [AW-1:0] res_in [7];
   logic [AW-1:0]        m_ff [3];
   logic [AW-1:0]        m_in [3];
   logic                 neg_ff [3];
   logic                 neg_in [3];
   logic [ROOT_W-1:0]    n_ff, n_in;
   logic [QW-1:0]        outv_ff [6];
   logic [QW-1:0]        outv_in [6];

   mac_cmd_type          mac_cmd;
   logic signed [DW-1:0] mac_a, mac_b;
   logic signed [AW-1:0] mac_acc;
   rdu_cmd_type          rdu_cmd;
   logic [ROOT_IN_W-1:0] rdu_num;
   logic [ROOT_W-1:0]    rdu_den;
   logic                 rdu_done;
   logic [ROOT_W-1:0]    rdu_result;

   logic                 req_fire;
   logic [AW-1:0]        w_or;
   logic signed [AW-1:0] csel;
   logic [NUM_W-1:0]     numer;
   logic [QW-1:0]        q;
   logic [2:0]           cap_idx;
   logic [2:0]           out_idx;

   ttf_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (mac_cmd),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (mac_acc)
   );

   ttf_rdu u_rdu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (rdu_cmd),
      .num    (rdu_num),
      .den    (rdu_den),
      .done   (rdu_done),
      .result (rdu_result)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign req_fire  = req_valid && req_ready;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      corner_in = corner_ff;
      cnt_in    = cnt_ff;
      vec_in    = vec_ff;
      comp_in   = comp_ff;
      run_in    = run_ff;
      slot_in   = slot_ff;
      degen_in  = degen_ff;
      held_pos_in = held_pos_ff;
      held_tex_in = held_tex_ff;
      e0_in  = e0_ff;
      e1_in  = e1_ff;
      du0_in = du0_ff;
      dv0_in = dv0_ff;
      du1_in = du1_ff;
      dv1_in = dv1_ff;
      res_in  = res_ff;
      m_in    = m_ff;
      neg_in  = neg_ff;
      n_in    = n_ff;
      outv_in = outv_ff;
      mac_cmd = '{valid: 1'b0, op: MAC_LOAD};
      mac_a   = '0;
      mac_b   = '0;
      rdu_cmd = '{start: 1'b0, is_div: 1'b0};
      rdu_den = n_ff;
      numer   = NUM_W'({m_ff[comp_ff][NORM_BITS-1:0], Q_SHIFT'(0)}) + NUM_W'(n_ff >> 1);
      rdu_num = ROOT_IN_W'(numer);
      q       = rdu_result[QW-1:0];
      w_or    = m_ff[0] | m_ff[1] | m_ff[2];
      cap_idx = 3'((cnt_ff - 4'd3) >> 1);
      out_idx = (vec_ff ? 3'd3 : 3'd0) + 3'(comp_ff);
      csel    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (corner_ff == 2'd0) begin
                  held_pos_in[0] = req_pos_x;
                  held_pos_in[1] = req_pos_y;
                  held_pos_in[2] = req_pos_z;
                  held_tex_in[0] = req_tex_u;
                  held_tex_in[1] = req_tex_v;
                  corner_in = 2'd1;
               end else if (corner_ff == 2'd1) begin
                  held_pos_in[3] = req_pos_x;
                  held_pos_in[4] = req_pos_y;
                  held_pos_in[5] = req_pos_z;
                  held_tex_in[2] = req_tex_u;
                  held_tex_in[3] = req_tex_v;
                  corner_in = 2'd2;
               end else begin
                  // edges and UV deltas, exact in 33 bits
                  e0_in[0] = {held_pos_ff[3][31], held_pos_ff[3]}
                           - {held_pos_ff[0][31], held_pos_ff[0]};
                  e0_in[1] = {held_pos_ff[4][31], held_pos_ff[4]}
                           - {held_pos_ff[1][31], held_pos_ff[1]};
                  e0_in[2] = {held_pos_ff[5][31], held_pos_ff[5]}
                           - {held_pos_ff[2][31], held_pos_ff[2]};
                  e1_in[0] = {req_pos_x[31], req_pos_x}
                           - {held_pos_ff[0][31], held_pos_ff[0]};
                  e1_in[1] = {req_pos_y[31], req_pos_y}
                           - {held_pos_ff[1][31], held_pos_ff[1]};
                  e1_in[2] = {req_pos_z[31], req_pos_z}
                           - {held_pos_ff[2][31], held_pos_ff[2]};
                  du0_in = {held_tex_ff[2][31], held_tex_ff[2]}
                         - {held_tex_ff[0][31], held_tex_ff[0]};
                  dv0_in = {held_tex_ff[3][31], held_tex_ff[3]}
                         - {held_tex_ff[1][31], held_tex_ff[1]};
                  du1_in = {req_tex_u[31], req_tex_u}
                         - {held_tex_ff[0][31], held_tex_ff[0]};
                  dv1_in = {req_tex_v[31], req_tex_v}
                         - {held_tex_ff[1][31], held_tex_ff[1]};
                  corner_in = 2'd0;
                  cnt_in    = '0;
                  state_in  = ST_MUL;
               end
            end
         end

         ST_MUL: begin
            // determinant, then tangent, then bitangent: pairs of products
            cnt_in = cnt_ff + 4'd1;
            mac_cmd.valid = (cnt_ff < 4'd14);
            mac_cmd.op    = cnt_ff[0] ? MAC_SUB : MAC_LOAD;
            case (cnt_ff)
               4'd0:  begin mac_a = du0_ff; mac_b = dv1_ff;   end
               4'd1:  begin mac_a = dv0_ff; mac_b = du1_ff;   end
               4'd2:  begin mac_a = dv1_ff; mac_b = e0_ff[0]; end
               4'd3:  begin mac_a = dv0_ff; mac_b = e1_ff[0]; end
               4'd4:  begin mac_a = dv1_ff; mac_b = e0_ff[1]; end
               4'd5:  begin mac_a = dv0_ff; mac_b = e1_ff[1]; end
               4'd6:  begin mac_a = dv1_ff; mac_b = e0_ff[2]; end
               4'd7:  begin mac_a = dv0_ff; mac_b = e1_ff[2]; end
               4'd8:  begin mac_a = du0_ff; mac_b = e1_ff[0]; end
               4'd9:  begin mac_a = du1_ff; mac_b = e0_ff[0]; end
               4'd10: begin mac_a = du0_ff; mac_b = e1_ff[1]; end
               4'd11: begin mac_a = du1_ff; mac_b = e0_ff[1]; end
               4'd12: begin mac_a = du0_ff; mac_b = e1_ff[2]; end
               4'd13: begin mac_a = du1_ff; mac_b = e0_ff[2]; end
               default: begin mac_a = '0; mac_b = '0; end
            endcase
            if (cnt_ff[0] && cnt_ff >= 4'd3) begin
               res_in[cap_idx] = mac_acc;
            end
            if (cnt_ff == 4'd15) begin
               if (res_ff[0] == '0) begin
                  degen_in = 1'b1;
                  for (int i = 0; i < 6; i++) outv_in[i] = '0;
                  slot_in  = '0;
                  state_in = ST_OUT;
               end else begin
                  degen_in = 1'b0;
                  vec_in   = 1'b0;
                  state_in = ST_LOAD;
               end
            end
         end

         ST_LOAD: begin
            // magnitudes and output signs, flipped by a negative determinant
            for (int i = 0; i < 3; i++) begin
               csel = vec_ff ? res_ff[4+i] : res_ff[1+i];
               m_in[i]   = csel[AW-1] ? (~csel + 1'b1) : csel;
               neg_in[i] = csel[AW-1] ^ res_ff[0][AW-1];
            end
            state_in = ST_NORM;
         end

         ST_NORM: begin
            // bring the largest magnitude to exactly NORM_BITS bits
            if (w_or == '0) begin
               for (int i = 0; i < 3; i++) begin
                  outv_in[(vec_ff ? 3 : 0) + i] = '0;
               end
               if (!vec_ff) begin
                  vec_in   = 1'b1;
                  state_in = ST_LOAD;
               end else begin
                  slot_in  = '0;
                  state_in = ST_OUT;
               end
            end else if (|w_or[AW-1:NORM_BITS]) begin
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] >> 1;
            end else if (!w_or[NORM_BITS-1]) begin
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] << 1;
            end else begin
               cnt_in   = '0;
               state_in = ST_SQ;
            end
         end

         ST_SQ: begin
            // sum of squares through the shared multiplier
            cnt_in = cnt_ff + 4'd1;
            mac_cmd.valid = (cnt_ff < 4'd3);
            mac_cmd.op    = (cnt_ff == 4'd0) ? MAC_LOAD : MAC_ADD;
            case (cnt_ff)
               4'd0:    mac_a = DW'(m_ff[0][NORM_BITS-1:0]);
               4'd1:    mac_a = DW'(m_ff[1][NORM_BITS-1:0]);
               4'd2:    mac_a = DW'(m_ff[2][NORM_BITS-1:0]);
               default: mac_a = '0;
            endcase
            mac_b = mac_a;
            if (cnt_ff == 4'd4) begin
               rdu_cmd  = '{start: 1'b1, is_div: 1'b0};
               rdu_num  = mac_acc[ROOT_IN_W-1:0];
               state_in = ST_ROOT;
            end
         end

         ST_ROOT: begin
            if (rdu_done) begin
               n_in     = rdu_result;
               comp_in  = '0;
               run_in   = 1'b0;
               state_in = ST_DIV;
            end
         end

         ST_DIV: begin
            // one rounded divide per component
            if (!run_ff) begin
               rdu_cmd = '{start: 1'b1, is_div: 1'b1};
               run_in  = 1'b1;
            end else if (rdu_done) begin
               outv_in[out_idx] = neg_ff[comp_ff] ? (~q + 1'b1) : q;
               run_in = 1'b0;
               if (comp_ff == 2'd2) begin
                  if (!vec_ff) begin
                     vec_in   = 1'b1;
                     state_in = ST_LOAD;
                  end else begin
                     slot_in  = '0;
                     state_in = ST_OUT;
                  end
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end
         end

         ST_OUT: begin
            if (rsp_ready) begin
               slot_in = slot_ff + 2'd1;
               if (slot_ff == 2'd2) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         corner_ff <= '0;
         slot_ff   <= '0;
         run_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         corner_ff <= corner_in;
         slot_ff   <= slot_in;
         run_ff    <= run_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      vec_ff      <= vec_in;
      comp_ff     <= comp_in;
      degen_ff    <= degen_in;
      held_pos_ff <= held_pos_in;
      held_tex_ff <= held_tex_in;
      e0_ff       <= e0_in;
      e1_ff       <= e1_in;
      du0_ff      <= du0_in;
      dv0_ff      <= dv0_in;
      du1_ff      <= du1_in;
      dv1_ff      <= dv1_in;
      res_ff      <= res_in;
      m_ff        <= m_in;
      neg_ff      <= neg_in;
      n_ff        <= n_in;
      outv_ff     <= outv_in;
   end

   assign rsp_tangent_x        = outv_ff[0];
   assign rsp_tangent_y        = outv_ff[1];
   assign rsp_tangent_z        = outv_ff[2];
   assign rsp_bitan_x          = outv_ff[3];
   assign rsp_bitan_y          = outv_ff[4];
   assign rsp_bitan_z          = outv_ff[5];
   assign rsp_vertex_slot      = slot_ff;
   assign rsp_degenerate       = degen_ff;
   assign rsp_last_of_triangle = (slot_ff == 2'd2);

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input accepted while results pending");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_tangent_x == 16'd0 && rsp_tangent_y == 16'd0 &&
         rsp_tangent_z == 16'd0 && rsp_bitan_x == 16'd0 && rsp_bitan_y == 16'd0 &&
         rsp_bitan_z == 16'd0)
      else $error("degenerate result with nonzero vectors");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_of_triangle |=> req_ready && corner_ff == 2'd0)
      else $error("block not ready for a new triangle");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_vertex_slot != 2'd3)
      else $error("corner slot out of range");

endmodule

### sim/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 800;
   localparam int RANDOM_TRIS    = 45;

   typedef struct packed {
      logic [31:0] px, py, pz, tu, tv;
   } vertex_type;

   typedef struct packed {
      logic [15:0] tx, ty, tz, bx, by, bz;
      logic [1:0]  slot;
      logic        degen;
      logic        last;
   } frame_type;

   // Tangent frame predictor and store of expected per-corner frames
   class frame_board;
      vertex_type corner[2];
      int         corner_idx;
      frame_type  frames_due[$];
      int         errors;
      int         triangles;
      int         degenerates;

      function new();
         corner_idx = 0;
         errors = 0;
         triangles = 0;
         degenerates = 0;
      endfunction

      static function int bit_len(logic [127:0] v);
         for (int i = 127; i >= 0; i--) begin
            if (v[i]) return i + 1;
         end
         return 0;
      endfunction

      static function logic [63:0] int_sqrt(logic [63:0] x);
         logic [63:0] r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // scale a vector to unit length in Q1.14, sign flipped when det < 0
      static function logic [47:0] unit_q14(logic signed [127:0] c0, logic signed [127:0] c1,
                                            logic signed [127:0] c2, bit flip);
         logic signed [127:0] c[3];
         logic [127:0] m[3];
         logic [63:0]  s[3];
         logic [63:0]  sum, n, q;
         logic [15:0]  r[3];
         bit           neg[3];
         int           len, sh;
         c[0] = c0; c[1] = c1; c[2] = c2;
         len = 0;
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            neg[i] = (c[i] < 0) != flip;
            m[i] = (c[i] < 0) ? -c[i] : c[i];
            if (bit_len(m[i]) > len) len = bit_len(m[i]);
         end
         if (len == 0) return 48'd0;
         for (int i = 0; i < 3; i++) begin
            if (len > 30) begin
               sh = len - 30;
               s[i] = 64'(m[i] >> sh);
            end else begin
               s[i] = 64'(m[i] << (30 - len));
            end
            sum = sum + s[i] * s[i];
         end
         n = int_sqrt(sum);
         for (int i = 0; i < 3; i++) begin
            q = (s[i] * 64'd16384 + n / 2) / n;
            r[i] = neg[i] ? 16'(17'h10000 - q[16:0]) : q[15:0];
         end
         return {r[0], r[1], r[2]};
      endfunction

      // accepted vertex: hold corners 0/1, on corner 2 predict three frames
      function void note_vertex(vertex_type v);
         logic signed [127:0] e0[3], e1[3], tw[3], bw[3];
         logic signed [127:0] du0, dv0, du1, dv1, det;
         logic signed [127:0] p0[3], p1[3], p2[3];
         logic [47:0] tq, bq;
         frame_type f;
         bit degen;
         if (corner_idx < 2) begin
            corner[corner_idx] = v;
            corner_idx++;
            return;
         end
         corner_idx = 0;
         triangles++;
         p0[0] = 128'(signed'(corner[0].px)); p1[0] = 128'(signed'(corner[1].px));
         p0[1] = 128'(signed'(corner[0].py)); p1[1] = 128'(signed'(corner[1].py));
         p0[2] = 128'(signed'(corner[0].pz)); p1[2] = 128'(signed'(corner[1].pz));
         p2[0] = 128'(signed'(v.px)); p2[1] = 128'(signed'(v.py)); p2[2] = 128'(signed'(v.pz));
         du0 = 128'(signed'(corner[1].tu)) - 128'(signed'(corner[0].tu));
         dv0 = 128'(signed'(corner[1].tv)) - 128'(signed'(corner[0].tv));
         du1 = 128'(signed'(v.tu)) - 128'(signed'(corner[0].tu));
         dv1 = 128'(signed'(v.tv)) - 128'(signed'(corner[0].tv));
         det = du0 * dv1 - dv0 * du1;
         degen = (det == 0);
         tq = 0;
         bq = 0;
         if (!degen) begin
            for (int i = 0; i < 3; i++) begin
               e0[i] = p1[i] - p0[i];
               e1[i] = p2[i] - p0[i];
               tw[i] = dv1 * e0[i] - dv0 * e1[i];
               bw[i] = du0 * e1[i] - du1 * e0[i];
            end
            tq = unit_q14(tw[0], tw[1], tw[2], det < 0);
            bq = unit_q14(bw[0], bw[1], bw[2], det < 0);
         end else begin
            degenerates++;
         end
         for (int k = 0; k < 3; k++) begin
            f = {tq, bq, 2'(k), degen, k == 2};
            frames_due.push_back(f);
         end
      endfunction

      function void check_frame(frame_type got);
         frame_type want;
         if (frames_due.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = frames_due.pop_front();
         if (got !== want) begin
            $display("%0t: mismatch expected tan %h %h %h bit %h %h %h slot %0d deg %b last %b",
                     $time, want.tx, want.ty, want.tz, want.bx, want.by, want.bz,
                     want.slot, want.degen, want.last);
            $display("%0t:          actual   tan %h %h %h bit %h %h %h slot %0d deg %b last %b",
                     $time, got.tx, got.ty, got.tz, got.bx, got.by, got.bz,
                     got.slot, got.degen, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [31:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0, req_tex_u = 0, req_tex_v = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [15:0] rsp_tangent_x, rsp_tangent_y, rsp_tangent_z;
   logic [15:0] rsp_bitan_x, rsp_bitan_y, rsp_bitan_z;
   logic [1:0]  rsp_vertex_slot;
   logic        rsp_degenerate, rsp_last_of_triangle;

   frame_board board = new();
   int  frames_taken = 0;
   int  idle_cycles = 0;

   triangle_tangent_frame dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(60, 10);
   endfunction

   task automatic send_vertex(vertex_type v);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1;
      {req_pos_x, req_pos_y, req_pos_z, req_tex_u, req_tex_v} = v;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_tri(vertex_type a, vertex_type b, vertex_type c);
      send_vertex(a);
      send_vertex(b);
      send_vertex(c);
   endtask

   function automatic vertex_type rand_vertex(int mode);
      vertex_type v;
      if (mode == 0) begin
         v = {$urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
         v.px = $urandom_range(32'h0040_0000) - 32'h0020_0000;
         v.py = $urandom_range(32'h0040_0000) - 32'h0020_0000;
         v.pz = $urandom_range(32'h0040_0000) - 32'h0020_0000;
         v.tu = $urandom_range(32'h0002_0000) - 32'h0001_0000;
         v.tv = $urandom_range(32'h0002_0000) - 32'h0001_0000;
      end
      return v;
   endfunction

   // acceptance monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_vertex({req_pos_x, req_pos_y, req_pos_z,
                                                        req_tex_u, req_tex_v});
         if (rsp_valid && rsp_ready) begin
            board.check_frame({rsp_tangent_x, rsp_tangent_y, rsp_tangent_z, rsp_bitan_x,
                               rsp_bitan_y, rsp_bitan_z, rsp_vertex_slot, rsp_degenerate,
                               rsp_last_of_triangle});
            frames_taken++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d frames outstanding", $time,
                     board.frames_due.size());
            $display("** triangle_tangent_frame: FAILED **");
            $finish;
         end
      end
   end

   // result side: random stalls, quiet stretches, one long hold-off
   initial begin
      int hold_left, quiet_left;
      bit held_once;
      hold_left = 0;
      quiet_left = 0;
      held_once = 0;
      forever begin
         @(negedge clock);
         if (!held_once && frames_taken >= 30) begin
            held_once = 1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 0;
         end else if (quiet_left > 0) begin
            quiet_left--;
            rsp_ready <= 1;
         end else if ($urandom_range(99) < 5) begin
            quiet_left = $urandom_range(80, 20);
            rsp_ready <= 1;
         end else if ($urandom_range(99) < 4) begin
            hold_left = $urandom_range(50, 10);
            rsp_ready <= 0;
         end else begin
            rsp_ready <= ($urandom_range(99) < 65);
         end
      end
   end

   // stimulus
   initial begin
      vertex_type a, b, c;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // simple right triangle, and one in another plane with U mirrored (negative det)
      send_tri({32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
               {32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0},
               {32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000});
      send_tri({32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
               {32'h0001_0000, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0},
               {32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000});
      // field extremes: widest deltas
      send_tri({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
               {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000},
               {32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
      send_tri({32'hFFFF_FFFF, 32'h0, 32'h1, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
               {32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF},
               {32'h1, 32'h1, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000});
      // zero determinant: identical UVs
      send_tri({32'h1234_5678, 32'h0, 32'h0, 32'h0000_8000, 32'h0000_8000},
               {32'h0, 32'h1234_5678, 32'h0, 32'h0000_8000, 32'h0000_8000},
               {32'h0, 32'h0, 32'h1234_5678, 32'h0000_8000, 32'h0000_8000});
      // zero determinant: collinear UVs
      send_tri({32'h0001_0000, 32'h2, 32'h3, 32'h0, 32'h0},
               {32'h4, 32'h0005_0000, 32'h6, 32'h0001_0000, 32'h0002_0000},
               {32'h7, 32'h8, 32'h0009_0000, 32'h0003_0000, 32'h0006_0000});
      // zero vectors with nonzero determinant: all positions equal
      send_tri({32'hDEAD_BEEF, 32'h1, 32'hF000_0000, 32'h0, 32'h0},
               {32'hDEAD_BEEF, 32'h1, 32'hF000_0000, 32'h0001_0000, 32'h0},
               {32'hDEAD_BEEF, 32'h1, 32'hF000_0000, 32'h0, 32'h0001_0000});
      // tiny deltas: vectors scaled up by a left shift
      send_tri({32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
               {32'h1, 32'h0, 32'h0, 32'h1, 32'h0},
               {32'h0, 32'h1, 32'h1, 32'h0, 32'h1});

      // random triangles: mostly full range, some small, some degenerate
      for (int t = 0; t < RANDOM_TRIS; t++) begin
         int mode;
         mode = $urandom_range(9) < 6 ? 0 : 1;
         a = rand_vertex(mode);
         b = rand_vertex(mode);
         c = rand_vertex(mode);
         if ($urandom_range(9) == 0) begin
            c.tu = a.tu;
            c.tv = a.tv;
         end
         send_tri(a, b, c);
      end
      req_valid = 0;

      while (board.frames_due.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Covered %0d triangles (%0d degenerate), %0d frames checked, one long stall.",
               board.triangles, board.degenerates, frames_taken);
      if (board.errors == 0 && board.frames_due.size() == 0) begin
         $display("** triangle_tangent_frame: PASSED **");
      end else begin
         $display("** triangle_tangent_frame: FAILED **");
      end
      $finish;
   end

endmodule

### files.f
rtl/ttf_pkg.sv
rtl/ttf_mac.sv
rtl/ttf_rdu.sv
rtl/triangle_tangent_frame.sv
sim/tb_top.sv
